// ===== rtl/pls_pkg.sv =====
// Package for the positional list store: payload structs, operation and
// status codes, controller states and the controller/datapath interface.
// No dependencies.
package pls_pkg;

  localparam logic [1:0] OP_APPEND   = 2'd0;
  localparam logic [1:0] OP_DEL_HEAD = 2'd1;
  localparam logic [1:0] OP_DEL_TAIL = 2'd2;
  localparam logic [1:0] OP_DEL_POS  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
    logic [7:0]               position;
  } pls_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] removed_value;
    logic [COUNT_W-1:0]       entry_count;
  } pls_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CAPT,
    S_SHIFT,
    S_DONE
  } pls_state_t;

  typedef struct packed {
    logic accept;
    logic advance;
    logic capture;
    logic shift_wr;
    logic count_dec;
    logic out_load;
  } pls_cmd_t;

  typedef struct packed {
    logic start_del;
    logic last;
    logic out_free;
  } pls_stat_t;

endpackage

// ===== rtl/pls_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module pls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pls_ctrl.sv =====
// Controller state machine of the positional list store.
// Depends on pls_pkg for states and the command and status structs.
module pls_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pls_pkg::pls_stat_t stat,
  output pls_pkg::pls_cmd_t  cmd
);
  import pls_pkg::*;

  pls_state_t state_r;
  pls_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.start_del ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: state_nxt = S_CAPT;
      S_CAPT, S_SHIFT: begin
        if (stat.last) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_FETCH: ;
      S_CAPT: begin
        cmd.capture   = 1'b1;
        cmd.advance   = 1'b1;
        cmd.count_dec = stat.last;
      end
      S_SHIFT: begin
        cmd.shift_wr  = 1'b1;
        cmd.advance   = 1'b1;
        cmd.count_dec = stat.last;
      end
      S_DONE: begin
        cmd.out_load = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/pls_dp.sv =====
// Datapath of the positional list store: entry RAM, count, shift pointer,
// result fields and output register. Depends on pls_pkg and pls_ram.
module pls_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pls_pkg::pls_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pls_pkg::pls_out_t out_data,
  input  pls_pkg::pls_cmd_t cmd,
  output pls_pkg::pls_stat_t stat
);
  import pls_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = CW + 8;

  logic [CW-1:0]     count_r;
  logic [AW-1:0]     ptr_r;
  logic [1:0]        status_r;
  logic [DATA_W-1:0] removed_r;
  logic              out_valid_r;
  pls_out_t          out_data_r;

  logic [1:0]        chk;
  logic [AW-1:0]     del_idx;
  logic              append_ok;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  always_comb begin
    chk = ST_OK;
    if (in_data.op == OP_APPEND) begin
      if (CMPW'(count_r) >= CMPW'(CAPACITY)) begin
        chk = ST_FULL;
      end
    end else if (count_r == '0) begin
      chk = ST_EMPTY;
    end else if (in_data.op == OP_DEL_POS) begin
      if (in_data.position == 8'd0 || CMPW'(in_data.position) > CMPW'(count_r)) begin
        chk = ST_NOTFOUND;
      end
    end
  end

  always_comb begin
    unique case (in_data.op)
      OP_DEL_HEAD: del_idx = '0;
      OP_DEL_TAIL: del_idx = AW'(count_r - 1'b1);
      OP_DEL_POS:  del_idx = AW'(in_data.position - 8'd1);
      default:     del_idx = '0;
    endcase
  end

  assign append_ok      = (chk == ST_OK) && (in_data.op == OP_APPEND);
  assign stat.start_del = (chk == ST_OK) && (in_data.op != OP_APPEND);
  assign stat.last      = ((CW + 1)'(ptr_r) + 1'b1) >= (CW + 1)'(count_r);
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign ram_we    = (cmd.accept && append_ok) || cmd.shift_wr;
  assign ram_waddr = cmd.shift_wr ? AW'(ptr_r - 1'b1) : AW'(count_r);
  assign ram_wdata = cmd.shift_wr ? ram_rdata : in_data.value;
  assign ram_raddr = cmd.advance ? AW'(ptr_r + 1'b1) : ptr_r;

  pls_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.accept && append_ok) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.count_dec) begin
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_r  <= chk;
      removed_r <= '0;
      ptr_r     <= del_idx;
    end else begin
      if (cmd.capture) begin
        removed_r <= ram_rdata;
      end
      if (cmd.advance) begin
        ptr_r <= AW'(ptr_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.status        <= status_r;
      out_data_r.removed_value <= removed_r;
      out_data_r.entry_count   <= COUNT_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/positional_list_store.sv =====
// Positional list store top level: an ordered list of signed 32-bit values
// in a RAM of CAPACITY entries. Depends on pls_pkg, pls_ctrl and pls_dp.
//
// One operation is taken at a time and gives one result. An append, and any
// operation that fails (full, empty, position not found), goes from the idle
// state straight to the done state, which loads the output register. A delete
// of the entry at zero-based index k from a list of n entries first reads and
// captures that entry; the later entries then move down through the single
// write port of the entry RAM, one entry per cycle. The result sits in an
// output register, so a waiting result holds back only the following
// operation's result, not its transfer. No clearing pass is needed after reset.
module positional_list_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pls_pkg::pls_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pls_pkg::pls_out_t out_data
);
  import pls_pkg::*;

  pls_cmd_t  cmd;
  pls_stat_t stat;

  pls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pls_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
